// ===== hdl/q2r_pkg.sv =====
// Shared widths and constants for the quaternion to rotation matrix block.
// No dependencies.
`default_nettype none
package q2r_pkg;
	localparam int IN_W    = 16;
	localparam int PROD_W  = 32;
	localparam int SUM_W   = 35;
	localparam int N2_W    = 33;
	localparam int MAG_W   = 34;
	localparam int QUO_W   = 15;
	localparam int REM_W   = MAG_W + QUO_W;
	localparam int DVS_W   = N2_W + 1;
	localparam int NENT    = 9;
	localparam int CFG_W   = 32;
	localparam int ADDR_W  = 3;

	localparam logic [CFG_W-1:0] MIN_NORM_RESET = 32'd17;
	localparam logic             REG_MIN_NORM   = 1'b0;
endpackage
`default_nettype wire

// ===== hdl/q2r_div_lane.sv =====
// Pipelined restoring divider lane, one quotient bit per stage.
// Depends on q2r_pkg.
`default_nettype none
module q2r_div_lane (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [q2r_pkg::REM_W-1:0]     rem_in,
	input  wire logic [q2r_pkg::DVS_W-1:0]     dvs_in,
	input  wire logic                          neg_in,
	output logic      [q2r_pkg::QUO_W-1:0]     quo,
	output logic                               neg
);
	localparam int NST = q2r_pkg::QUO_W;

	logic [q2r_pkg::REM_W-1:0] rem_sk [0:NST];
	logic [q2r_pkg::DVS_W-1:0] dvs_sk [0:NST];
	logic [q2r_pkg::QUO_W-1:0] quo_sk [0:NST];
	logic                      neg_sk [0:NST];

	assign rem_sk[0] = rem_in;
	assign dvs_sk[0] = dvs_in;
	assign quo_sk[0] = '0;
	assign neg_sk[0] = neg_in;

	for (genvar k = 0; k < NST; k++) begin : g_step
		localparam int SH = NST - 1 - k;
		logic [q2r_pkg::REM_W-1:0] sub;
		logic                      take;
		assign sub  = {{(q2r_pkg::REM_W-q2r_pkg::DVS_W){1'b0}}, dvs_sk[k]} << SH;
		assign take = rem_sk[k] >= sub;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k+1] <= take ? rem_sk[k] - sub : rem_sk[k];
				dvs_sk[k+1] <= dvs_sk[k];
				quo_sk[k+1] <= {quo_sk[k][q2r_pkg::QUO_W-2:0], take};
				neg_sk[k+1] <= neg_sk[k];
			end
		end
	end

	assign quo = quo_sk[NST];
	assign neg = neg_sk[NST];
endmodule
`default_nettype wire

// ===== hdl/quaternion_to_rotation_matrix.sv =====
// Quaternion to 3x3 rotation matrix, top level with APB register port.
// Depends on q2r_pkg and q2r_div_lane.
//
// Takes one quaternion (w,x,y,z) in signed Q4.12 per cycle and returns the
// rotation matrix of its normalized form in signed Q2.14, each entry
// num/n2 rounded to nearest, ties away from zero. The pipeline has a
// product stage, a sum stage, a setup stage, 15 divider stages (one quotient
// bit each, nine lanes in parallel) and the output register. One item per
// cycle is sustained; a result held by out_stall freezes the whole pipe.
// Quaternions with n2 == 0 or n2 below min_norm_squared (address 0,
// reset 17) come out with valid_res low and all entries zero.
`default_nettype none
module quaternion_to_rotation_matrix (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [q2r_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [q2r_pkg::CFG_W-1:0]         pwdata,
	output logic      [q2r_pkg::CFG_W-1:0]         prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [q2r_pkg::IN_W-1:0]   quat_w,
	input  wire logic signed [q2r_pkg::IN_W-1:0]   quat_x,
	input  wire logic signed [q2r_pkg::IN_W-1:0]   quat_y,
	input  wire logic signed [q2r_pkg::IN_W-1:0]   quat_z,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   valid_res,
	output logic signed [q2r_pkg::IN_W-1:0]        m00,
	output logic signed [q2r_pkg::IN_W-1:0]        m01,
	output logic signed [q2r_pkg::IN_W-1:0]        m02,
	output logic signed [q2r_pkg::IN_W-1:0]        m10,
	output logic signed [q2r_pkg::IN_W-1:0]        m11,
	output logic signed [q2r_pkg::IN_W-1:0]        m12,
	output logic signed [q2r_pkg::IN_W-1:0]        m20,
	output logic signed [q2r_pkg::IN_W-1:0]        m21,
	output logic signed [q2r_pkg::IN_W-1:0]        m22
);
	localparam int SW  = q2r_pkg::SUM_W;
	localparam int PW  = q2r_pkg::PROD_W;
	localparam int NE  = q2r_pkg::NENT;
	localparam int DEP = q2r_pkg::QUO_W;

	logic [q2r_pkg::CFG_W-1:0] min_norm_q;
	logic                      en;

	// config port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_norm_q <= q2r_pkg::MIN_NORM_RESET;
		end else if (psel && penable && pwrite && paddr[2] == q2r_pkg::REG_MIN_NORM) begin
			min_norm_q <= pwdata;
		end
	end
	assign prdata = (paddr[2] == q2r_pkg::REG_MIN_NORM) ? min_norm_q : '0;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] p);
		ext = {{(SW-PW){p[PW-1]}}, p};
	endfunction

	// stage 1: products
	logic signed [PW-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1;
	logic signed [PW-1:0] xw_s1, yw_s1, zw_s1;
	logic                 vld_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= quat_w * quat_w;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			xy_s1 <= quat_x * quat_y;
			xz_s1 <= quat_x * quat_z;
			yz_s1 <= quat_y * quat_z;
			xw_s1 <= quat_x * quat_w;
			yw_s1 <= quat_y * quat_w;
			zw_s1 <= quat_z * quat_w;
		end
	end

	// stage 2: norm and numerators
	logic signed [SW-1:0]            n2c;
	logic signed [SW-1:0]            num_c [0:NE-1];
	logic        [q2r_pkg::N2_W-1:0] n2_s2;
	logic signed [SW-1:0]            num_s2 [0:NE-1];
	logic                            ok_s2, vld_s2;
	always_comb begin
		n2c      = ext(ww_s1) + ext(xx_s1) + ext(yy_s1) + ext(zz_s1);
		num_c[0] = n2c - ((ext(yy_s1) + ext(zz_s1)) <<< 1);
		num_c[1] = (ext(xy_s1) + ext(zw_s1)) <<< 1;
		num_c[2] = (ext(xz_s1) - ext(yw_s1)) <<< 1;
		num_c[3] = (ext(xy_s1) - ext(zw_s1)) <<< 1;
		num_c[4] = n2c - ((ext(xx_s1) + ext(zz_s1)) <<< 1);
		num_c[5] = (ext(yz_s1) + ext(xw_s1)) <<< 1;
		num_c[6] = (ext(xz_s1) + ext(yw_s1)) <<< 1;
		num_c[7] = (ext(yz_s1) - ext(xw_s1)) <<< 1;
		num_c[8] = n2c - ((ext(xx_s1) + ext(yy_s1)) <<< 1);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n2_s2  <= n2c[q2r_pkg::N2_W-1:0];
			num_s2 <= num_c;
			ok_s2  <= (n2c != '0) &&
				(n2c[q2r_pkg::N2_W-1:0] >= {1'b0, min_norm_q});
		end
	end

	// stage 3: magnitude, rounding offset, divisor
	logic [q2r_pkg::REM_W-1:0] rem_s3 [0:NE-1];
	logic                      neg_s3 [0:NE-1];
	logic [q2r_pkg::DVS_W-1:0] dvs_s3;
	logic                      ok_s3, vld_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NE; e++) begin
				logic signed [SW-1:0] mg;
				mg = num_s2[e][SW-1] ? -num_s2[e] : num_s2[e];
				neg_s3[e] <= num_s2[e][SW-1];
				rem_s3[e] <= {mg[q2r_pkg::MAG_W-1:0], {q2r_pkg::QUO_W{1'b0}}}
					+ {{(q2r_pkg::REM_W-q2r_pkg::N2_W){1'b0}}, n2_s2};
			end
			dvs_s3 <= {n2_s2, 1'b0};
			ok_s3  <= ok_s2;
		end
	end

	// divider lanes
	logic [q2r_pkg::QUO_W-1:0] quo [0:NE-1];
	logic                      qneg [0:NE-1];
	for (genvar e = 0; e < NE; e++) begin : g_lane
		q2r_div_lane u_lane (
			.clk    (clk),
			.en     (en),
			.rem_in (rem_s3[e]),
			.dvs_in (dvs_s3),
			.neg_in (neg_s3[e]),
			.quo    (quo[e]),
			.neg    (qneg[e])
		);
	end

	logic ok_sd [0:DEP];
	logic vld_sd [0:DEP];
	assign ok_sd[0]  = ok_s3;
	assign vld_sd[0] = vld_s3;
	for (genvar k = 0; k < DEP; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) ok_sd[k+1] <= ok_sd[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k+1] <= 1'b0;
			end else if (en) begin
				vld_sd[k+1] <= vld_sd[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			out_valid <= vld_sd[DEP];
		end
	end

	// output register
	logic signed [q2r_pkg::IN_W-1:0] ent_c  [0:NE-1];
	logic signed [q2r_pkg::IN_W-1:0] ent_so [0:NE-1];
	always_comb begin
		for (int e = 0; e < NE; e++) begin
			logic signed [q2r_pkg::IN_W-1:0] qv;
			qv       = {1'b0, quo[e]};
			ent_c[e] = !ok_sd[DEP] ? '0 : (qneg[e] ? -qv : qv);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ent_so    <= ent_c;
			valid_res <= ok_sd[DEP];
		end
	end

	assign m00 = ent_so[0];
	assign m01 = ent_so[1];
	assign m02 = ent_so[2];
	assign m10 = ent_so[3];
	assign m11 = ent_so[4];
	assign m12 = ent_so[5];
	assign m20 = ent_so[6];
	assign m21 = ent_so[7];
	assign m22 = ent_so[8];

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> m00 == 0 && m01 == 0 && m02 == 0 &&
			m10 == 0 && m11 == 0 && m12 == 0 && m20 == 0 && m21 == 0 && m22 == 0)
		else $error("rejected item carries nonzero entries");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> m00 <= 16384 && m00 >= -16384 &&
			m11 <= 16384 && m11 >= -16384 && m22 <= 16384 && m22 >= -16384 &&
			m01 <= 16384 && m01 >= -16384)
		else $error("entry exceeds unit magnitude");
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for quaternion_to_rotation_matrix.
// Depends on q2r_pkg and the block's RTL; drives random and corner quaternions
// under random gaps and stalls and checks every matrix against its own predictor.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [q2r_pkg::IN_W-1:0] w, x, y, z;
	} quat_t;

	typedef struct {
		logic                            ok;
		logic signed [q2r_pkg::IN_W-1:0] e [q2r_pkg::NENT];
	} mat_t;

	localparam logic [q2r_pkg::ADDR_W-1:0] ADDR_MIN_NORM =
		q2r_pkg::ADDR_W'(q2r_pkg::REG_MIN_NORM) << 2;
	localparam logic [q2r_pkg::ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
	localparam int IDLE_LIMIT = 4000;
	localparam int LATENCY = 19;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [q2r_pkg::ADDR_W-1:0] paddr = '0;
	logic [q2r_pkg::CFG_W-1:0] pwdata = '0;
	logic [q2r_pkg::CFG_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [q2r_pkg::IN_W-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic valid_res;
	logic signed [q2r_pkg::IN_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	quaternion_to_rotation_matrix DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	quat_t quat_pending[$];
	mat_t  mat_expect[$];
	logic [q2r_pkg::CFG_W-1:0] norm_floor = q2r_pkg::MIN_NORM_RESET;
	int errors = 0, n_in = 0, n_out = 0, n_rejected = 0, n_phases = 0;
	int idle_cycles = 0;
	logic in_took = 1'b0;

	function automatic logic signed [q2r_pkg::IN_W-1:0] ratio_q14(longint num, longint den);
		longint unsigned mag, q;
		longint r;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		q = ((mag << 15) + den) / (den * 2);
		r = (num < 0) ? -longint'(q) : longint'(q);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[q2r_pkg::IN_W-1:0];
	endfunction

	function automatic mat_t rotation_of(quat_t q);
		mat_t m;
		longint w, x, y, z, n2;
		w = longint'(q.w); x = longint'(q.x); y = longint'(q.y); z = longint'(q.z);
		n2 = w*w + x*x + y*y + z*z;
		m.ok = !(n2 == 0 || n2 < longint'(norm_floor));
		for (int k = 0; k < q2r_pkg::NENT; k++) m.e[k] = '0;
		if (m.ok) begin
			m.e[0] = ratio_q14(n2 - 2*(y*y + z*z), n2);
			m.e[1] = ratio_q14(2*(x*y + z*w), n2);
			m.e[2] = ratio_q14(2*(x*z - y*w), n2);
			m.e[3] = ratio_q14(2*(x*y - z*w), n2);
			m.e[4] = ratio_q14(n2 - 2*(x*x + z*z), n2);
			m.e[5] = ratio_q14(2*(y*z + x*w), n2);
			m.e[6] = ratio_q14(2*(x*z + y*w), n2);
			m.e[7] = ratio_q14(2*(y*z - x*w), n2);
			m.e[8] = ratio_q14(n2 - 2*(x*x + y*y), n2);
		end
		return m;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("[%0t] %s: got %0d expected %0d", $time, what, got, want);
	endtask

	// input side: record expectation per accepted item
	always @(posedge clk) begin
		quat_t q;
		in_took <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			q.w = quat_w; q.x = quat_x; q.y = quat_y; q.z = quat_z;
			mat_expect.push_back(rotation_of(q));
			n_in++;
		end
	end

	// output side: compare against oldest expectation
	always @(posedge clk) begin
		mat_t want;
		logic signed [q2r_pkg::IN_W-1:0] got [q2r_pkg::NENT];
		if (out_valid && !out_stall) begin
			n_out++;
			got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			if (mat_expect.size() == 0) begin
				report("unexpected item", longint'(0), longint'(0));
			end else begin
				want = mat_expect.pop_front();
				if (!want.ok) n_rejected++;
				if (valid_res !== want.ok)
					report("valid_res", longint'(valid_res), longint'(want.ok));
				for (int k = 0; k < q2r_pkg::NENT; k++)
					if (got[k] !== want.e[k])
						report($sformatf("m%0d%0d", k / 3, k % 3),
							longint'(got[k]), longint'(want.e[k]));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// sender: bursts with random gaps
	int burst_left = 4, gap_left = 0;
	always @(negedge clk) begin
		quat_t q;
		if (arst_n && !(in_valid && !in_took)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (quat_pending.size() > 0) begin
				q = quat_pending.pop_front();
				quat_w <= q.w; quat_x <= q.x; quat_y <= q.y; quat_z <= q.z;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches mode every so often
	int stall_mode = 0, stall_span = 0;
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(10, 60);
			out_stall <= 1'b0;
		end else begin
			stall_span <= stall_span - 1;
			case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= ($urandom_range(0, 9) < 8);
			default: out_stall <= stall_span[2];
			endcase
		end
	end

	task automatic reg_write(logic [q2r_pkg::ADDR_W-1:0] a, logic [q2r_pkg::CFG_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= v; penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (a == ADDR_MIN_NORM) norm_floor = v;
	endtask

	task automatic check_floor();
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b0; paddr <= ADDR_MIN_NORM; penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== norm_floor)
			report("min_norm_squared readback", longint'(prdata), longint'(norm_floor));
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	task automatic push_quat(int w, int x, int y, int z);
		quat_t q;
		q.w = q2r_pkg::IN_W'(w);
		q.x = q2r_pkg::IN_W'(x);
		q.y = q2r_pkg::IN_W'(y);
		q.z = q2r_pkg::IN_W'(z);
		quat_pending.push_back(q);
	endtask

	function automatic int rand_part(int mode);
		case (mode)
		0, 1, 2, 3: return int'($signed(16'($urandom)));
		4, 5: return $urandom_range(0, 128) - 64;
		6, 7: return $urandom_range(0, 8192) - 4096;
		8: return $urandom_range(0, 10) - 5;
		default: begin
			case ($urandom_range(0, 4))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return 1;
			default: return -1;
			endcase
		end
		endcase
	endfunction

	task automatic wait_drained();
		while (quat_pending.size() > 0 || in_valid || mat_expect.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 6) @(posedge clk);
	endtask

	task automatic random_items(int count);
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(0, 9);
			push_quat(rand_part(mode), rand_part(mode), rand_part(mode), rand_part(mode));
		end
	endtask

	initial begin
		logic [q2r_pkg::CFG_W-1:0] floors [5];
		floors = '{32'd0, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0001_0000,
			q2r_pkg::MIN_NORM_RESET};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_floor();
		// corners at the reset threshold
		push_quat(0, 0, 0, 0);
		push_quat(4096, 0, 0, 0);
		push_quat(0, 4096, 0, 0);
		push_quat(0, 0, 4096, 0);
		push_quat(0, 0, 0, 4096);
		push_quat(4, 0, 0, 0);
		push_quat(4, 1, 0, 0);
		push_quat(-4, 0, 1, 0);
		push_quat(-32768, -32768, -32768, -32768);
		push_quat(32767, 32767, 32767, 32767);
		push_quat(32767, -32768, 32767, -32768);
		push_quat(-32768, 0, 0, 0);
		push_quat(0, 32767, -32768, 0);
		push_quat(2896, 2896, 0, 0);
		push_quat(1, -1, 1, -1);
		push_quat(-1, 0, 0, 0);
		push_quat(0, 0, 0, 1);
		push_quat(1234, -5678, 9012, -3456);
		random_items(120);
		n_phases++;
		foreach (floors[p]) begin
			wait_drained();
			reg_write(ADDR_MIN_NORM, floors[p]);
			reg_write(ADDR_UNMAPPED, 32'h0000_0005);
			check_floor();
			push_quat(0, 0, 0, 0);
			push_quat(1, 0, 0, 0);
			push_quat(4096, 0, 0, 0);
			push_quat(-32768, -32768, -32768, -32768);
			random_items(105);
			n_phases++;
		end
		wait_drained();
		$display("%0d quaternions in, %0d matrices out (%0d rejected), %0d thresholds",
			n_in, n_out, n_rejected, n_phases);
		if (errors == 0 && mat_expect.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire
